// File: hw/rtl/tiny_load_store_cpu_execute_unit_assert.svh
// Assertion macros for the load/store execute unit.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef TINY_LOAD_STORE_CPU_EXECUTE_UNIT_ASSERT_SVH
`define TINY_LOAD_STORE_CPU_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tlsc_pkg.sv
// Shared types and constants for the load/store execute unit.
// No dependencies.
package tlsc_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int OP_W       = 3;
  localparam int OUT_ADDR_W = 4;

  // Memory reset image: all zero except one word
  localparam int               MEM_INIT_ADDR = 1;
  localparam logic [DATA_W-1:0] MEM_INIT_WORD = 32'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_IMM  = 3'd0,
    OP_LOAD_WORD = 3'd1,
    OP_STORE     = 3'd2,
    OP_ADD       = 3'd3,
    OP_MUL       = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MEMRD,
    ST_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic exec;
    logic mem_capture;
    logic mul_step;
    logic finish;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic addr_fault;
    logic mul_done;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/tlsc_channels.sv
// Request and result channel interfaces for the load/store execute unit.
// Depends on tlsc_pkg for field widths.
interface tlsc_in_if;
  logic                              valid;
  logic                              ready;
  logic [tlsc_pkg::OP_W-1:0]         req_type;
  logic [tlsc_pkg::IDX_W-1:0]        dest_index;
  logic [tlsc_pkg::IDX_W-1:0]        source_index;
  logic signed [tlsc_pkg::DATA_W-1:0] immediate_value;

  modport source (output valid, req_type, dest_index, source_index, immediate_value,
                  input ready);
  modport sink   (input valid, req_type, dest_index, source_index, immediate_value,
                  output ready);
endinterface

interface tlsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tlsc_pkg::DATA_W-1:0] written_value;
  logic                               reg_written;
  logic                               mem_written;
  logic [tlsc_pkg::OUT_ADDR_W-1:0]    access_address;
  logic                               address_fault;

  modport source (output valid, written_value, reg_written, mem_written, access_address,
                  address_fault, input ready);
  modport sink   (input valid, written_value, reg_written, mem_written, access_address,
                  address_fault, output ready);
endinterface

// File: hw/rtl/tlsc_regfile.sv
// Register file: two registered read ports, one write port, per-entry valid bits.
// Depends on tlsc_pkg.
module tlsc_regfile #(
  parameter int REG_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [$clog2(REG_COUNT)-1:0]       rd_a_addr,
  input  logic [$clog2(REG_COUNT)-1:0]       rd_b_addr,
  output logic [tlsc_pkg::DATA_W-1:0]        rd_a_data,
  output logic [tlsc_pkg::DATA_W-1:0]        rd_b_data,
  input  logic                               wr_en,
  input  logic [$clog2(REG_COUNT)-1:0]       wr_addr,
  input  logic [tlsc_pkg::DATA_W-1:0]        wr_data
);

  logic [tlsc_pkg::DATA_W-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0]        valid_r;
  logic [tlsc_pkg::DATA_W-1:0] a_q_r, b_q_r;
  logic                        a_v_r, b_v_r;

  // valid bits stand in for the all-zero reset of the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_q_r <= mem[rd_a_addr];
      b_q_r <= mem[rd_b_addr];
      a_v_r <= valid_r[rd_a_addr];
      b_v_r <= valid_r[rd_b_addr];
    end
  end

  assign rd_a_data = a_v_r ? a_q_r : '0;
  assign rd_b_data = b_v_r ? b_q_r : '0;

endmodule

// File: hw/rtl/tlsc_dmem.sv
// Data memory: one write port, one registered read port, no reset.
// Depends on tlsc_pkg.
module tlsc_dmem #(
  parameter int MEM_WORDS = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MEM_WORDS)-1:0] wr_addr,
  input  logic [tlsc_pkg::DATA_W-1:0]  wr_data,
  input  logic [$clog2(MEM_WORDS)-1:0] rd_addr,
  output logic [tlsc_pkg::DATA_W-1:0]  rd_data
);

  logic [tlsc_pkg::DATA_W-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/tlsc_datapath.sv
// Datapath: operand latch, register file, data memory, shift-add multiplier,
// clear counter and result register. Depends on tlsc_pkg, tlsc_regfile, tlsc_dmem.
module tlsc_datapath #(
  parameter int MEM_WORDS = 16,
  parameter int REG_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlsc_pkg::ctrl_cmd_t                cmd,
  output tlsc_pkg::dp_status_t               status,
  input  logic [tlsc_pkg::OP_W-1:0]          in_req_type,
  input  logic [tlsc_pkg::IDX_W-1:0]         in_dest_index,
  input  logic [tlsc_pkg::IDX_W-1:0]         in_source_index,
  input  logic [tlsc_pkg::DATA_W-1:0]        in_immediate,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [tlsc_pkg::DATA_W-1:0]        out_wval,
  output logic                               out_rw,
  output logic                               out_mw,
  output logic [tlsc_pkg::OUT_ADDR_W-1:0]    out_addr,
  output logic                               out_fault
);

  localparam int RIDX_W  = $clog2(REG_COUNT);
  localparam int MADDR_W = $clog2(MEM_WORDS);
  localparam int DW      = tlsc_pkg::DATA_W;

  // index mod REG_COUNT for a 3-bit index: at most four subtractions
  function automatic logic [RIDX_W-1:0] reg_slot(input logic [tlsc_pkg::IDX_W-1:0] idx);
    logic [5:0] v;
    v = {3'b000, idx};
    for (int i = 0; i < 4; i++) begin
      if (v >= 6'(REG_COUNT)) v = v - 6'(REG_COUNT);
    end
    return RIDX_W'(v);
  endfunction

  tlsc_pkg::op_t              op_r;
  logic [RIDX_W-1:0]          d_idx_r;
  logic [DW-1:0]              imm_r;
  logic [DW-1:0]              rd_d, rd_s;
  logic [DW-1:0]              mem_q;
  logic [DW-1:0]              wval_r, mcand_r, mplier_r;
  logic                       rw_r, mw_r, fault_r;
  logic [tlsc_pkg::OUT_ADDR_W-1:0] addr_r;
  logic [MADDR_W-1:0]         clr_idx_r;
  logic                       out_valid_r;
  logic                       fault;

  logic [DW-1:0]              ex_wval;
  logic                       ex_rw, ex_mw, ex_fault;
  logic [tlsc_pkg::OUT_ADDR_W-1:0] ex_addr;

  logic                       mem_we;
  logic [MADDR_W-1:0]         mem_waddr;
  logic [DW-1:0]              mem_wdata;

  tlsc_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (cmd.accept),
    .rd_a_addr (reg_slot(in_dest_index)),
    .rd_b_addr (reg_slot(in_source_index)),
    .rd_a_data (rd_d),
    .rd_b_data (rd_s),
    .wr_en     (cmd.finish && rw_r),
    .wr_addr   (d_idx_r),
    .wr_data   (wval_r)
  );

  tlsc_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (rd_s[MADDR_W-1:0]),
    .rd_data (mem_q)
  );

  assign fault = (rd_s >= DW'(MEM_WORDS));

  always_comb begin
    ex_wval  = '0;
    ex_rw    = 1'b0;
    ex_mw    = 1'b0;
    ex_fault = 1'b0;
    ex_addr  = '0;
    unique case (op_r)
      tlsc_pkg::OP_LOAD_IMM: begin
        ex_wval = imm_r;
        ex_rw   = 1'b1;
      end
      tlsc_pkg::OP_LOAD_WORD: begin
        if (fault) begin
          ex_fault = 1'b1;
        end else begin
          ex_rw   = 1'b1;
          ex_addr = rd_s[tlsc_pkg::OUT_ADDR_W-1:0];
        end
      end
      tlsc_pkg::OP_STORE: begin
        if (fault) begin
          ex_fault = 1'b1;
        end else begin
          ex_wval = rd_d;
          ex_mw   = 1'b1;
          ex_addr = rd_s[tlsc_pkg::OUT_ADDR_W-1:0];
        end
      end
      tlsc_pkg::OP_ADD: begin
        ex_wval = rd_d + rd_s;
        ex_rw   = 1'b1;
      end
      tlsc_pkg::OP_MUL: begin
        ex_rw = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory write port: clear sweep after reset, else store
  always_comb begin
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = (clr_idx_r == MADDR_W'(tlsc_pkg::MEM_INIT_ADDR)) ?
                  tlsc_pkg::MEM_INIT_WORD : '0;
    end else begin
      mem_we    = cmd.exec && ex_mw;
      mem_waddr = rd_s[MADDR_W-1:0];
      mem_wdata = rd_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear_step) begin
      clr_idx_r <= clr_idx_r + MADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= tlsc_pkg::op_t'(in_req_type);
      d_idx_r <= reg_slot(in_dest_index);
      imm_r   <= in_immediate;
    end
  end

  // result fields; wval_r doubles as the multiplier accumulator
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      wval_r   <= ex_wval;
      rw_r     <= ex_rw;
      mw_r     <= ex_mw;
      fault_r  <= ex_fault;
      addr_r   <= ex_addr;
      mcand_r  <= rd_d;
      mplier_r <= rd_s;
    end else if (cmd.mem_capture) begin
      wval_r <= mem_q;
    end else if (cmd.mul_step) begin
      if (mplier_r[0]) wval_r <= wval_r + mcand_r;
      mcand_r  <= {mcand_r[DW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[DW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_wval  <= wval_r;
      out_rw    <= rw_r;
      out_mw    <= mw_r;
      out_addr  <= addr_r;
      out_fault <= fault_r;
    end
  end

  assign out_valid = out_valid_r;

  assign status.op         = op_r;
  assign status.addr_fault = fault;
  assign status.mul_done   = (mplier_r == '0);
  assign status.clr_last   = (clr_idx_r == MADDR_W'(MEM_WORDS - 1));
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

// File: hw/rtl/tlsc_ctrl.sv
// Controller state machine: sequences clear, fetch, execute, memory read, multiply and finish.
// Depends on tlsc_pkg.
module tlsc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  tlsc_pkg::dp_status_t status,
  output tlsc_pkg::ctrl_cmd_t  cmd
);

  tlsc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlsc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlsc_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = tlsc_pkg::ST_IDLE;
      end
      tlsc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tlsc_pkg::ST_FETCH;
      end
      tlsc_pkg::ST_FETCH: begin
        unique case (status.op)
          tlsc_pkg::OP_LOAD_WORD:
            state_nxt = status.addr_fault ? tlsc_pkg::ST_FINISH : tlsc_pkg::ST_MEMRD;
          tlsc_pkg::OP_MUL: state_nxt = tlsc_pkg::ST_MUL;
          default:          state_nxt = tlsc_pkg::ST_FINISH;
        endcase
      end
      tlsc_pkg::ST_MEMRD: begin
        state_nxt = tlsc_pkg::ST_FINISH;
      end
      tlsc_pkg::ST_MUL: begin
        if (status.mul_done) state_nxt = tlsc_pkg::ST_FINISH;
      end
      tlsc_pkg::ST_FINISH: begin
        if (status.out_free) state_nxt = tlsc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tlsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.clear_step  = (state_r == tlsc_pkg::ST_CLEAR);
    cmd.ready       = (state_r == tlsc_pkg::ST_IDLE);
    cmd.accept      = (state_r == tlsc_pkg::ST_IDLE) && in_valid;
    cmd.exec        = (state_r == tlsc_pkg::ST_FETCH);
    cmd.mem_capture = (state_r == tlsc_pkg::ST_MEMRD);
    cmd.mul_step    = (state_r == tlsc_pkg::ST_MUL) && !status.mul_done;
    cmd.finish      = (state_r == tlsc_pkg::ST_FINISH) && status.out_free;
  end

endmodule

// File: hw/rtl/tiny_load_store_cpu_execute_unit.sv
// From request accept to result valid: load immediate, add, store, faults and unknown
// ops pass through the fetch and finish states; load word adds a memory read state;
// multiply adds the shift-add loop, one step per bit of the source operand up to its
// highest set bit (at most 32 steps). Finish waits while an earlier result is untaken.
// One request in flight; the next is taken in the idle state after the finish state.
// Reset (sync, active low): register file reads zero; a clearing pass then writes all
// MEM_WORDS words of the data memory, one word per cycle, before the first request is taken.
//
// Top level of the load/store execute unit. Depends on tlsc_pkg, the channel
// interfaces, tlsc_ctrl, tlsc_datapath and the assertion macro header.
`include "tiny_load_store_cpu_execute_unit_assert.svh"

module tiny_load_store_cpu_execute_unit #(
  parameter int MEM_WORDS = 16,
  parameter int REG_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  tlsc_in_if.sink     in_chan,
  tlsc_out_if.source  out_chan
);

  tlsc_pkg::ctrl_cmd_t  cmd;
  tlsc_pkg::dp_status_t status;

  logic [tlsc_pkg::DATA_W-1:0] out_wval;

  // Controller: owns sequencing only, sees the datapath through status.
  tlsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: operands, storage, multiplier and the result register that lets
  // the next request be taken while a result waits on the consumer.
  tlsc_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .REG_COUNT (REG_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_req_type     (in_chan.req_type),
    .in_dest_index   (in_chan.dest_index),
    .in_source_index (in_chan.source_index),
    .in_immediate    ($unsigned(in_chan.immediate_value)),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_wval        (out_wval),
    .out_rw          (out_chan.reg_written),
    .out_mw          (out_chan.mem_written),
    .out_addr        (out_chan.access_address),
    .out_fault       (out_chan.address_fault)
  );

  assign in_chan.ready          = cmd.ready;
  assign out_chan.written_value = $signed(out_wval);

  // An accepted request is always executed in the following cycle.
  `TLSC_ASSERT_NEXT(a_accept_then_exec, in_chan.valid && in_chan.ready, cmd.exec, "exec missed")
  // A result is never registered over one the consumer has not taken.
  `TLSC_ASSERT_NOW(a_finish_needs_slot, cmd.finish, status.out_free, "result slot busy")
  // The multiplier never steps past the end of its operand.
  `TLSC_ASSERT_NOW(a_mul_step_bounded, cmd.mul_step, !status.mul_done && !cmd.finish, "extra mul step")
  // Result valid only rises after a finish command.
  `TLSC_ASSERT_NOW(a_out_from_finish, $rose(out_chan.valid), $past(cmd.finish), "stray result valid")

endmodule
